// ----- rtl/ddsh_pkg.sv -----
`default_nettype none

package ddsh_pkg;

    localparam int COUNT_BITS_DEF = 14;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int PROD_W   = 66;
    localparam int M_DATA_W = 160;
    localparam int CFG_W    = 32;

    localparam logic [16:0] COEF_ONE     = 17'd65536;
    localparam logic [32:0] ANG_K        = 33'd4575416;
    localparam logic [15:0] HALF_DIVISOR = 16'd16383;
    localparam logic [15:0] DIVISOR      = 16'd32767;

    localparam logic [16:0] SPEED_COEF_RST  = 17'd6554;
    localparam logic [16:0] YAW_COEF_RST    = 17'd6554;
    localparam logic [31:0] DIST_PER_CNT_RST = 32'd65536;
    localparam logic [15:0] GYRO_BIAS_RST   = 16'd0;
    localparam logic [31:0] SPEED_GAIN_RST  = 32'd393216;
    localparam logic [31:0] HDG_GAIN_RST    = 32'd983;
    localparam logic [14:0] PWM_PERIOD_RST  = 15'd1000;

    typedef enum logic [2:0] {
        REG_SPEED_COEF   = 3'd0,
        REG_YAW_COEF     = 3'd1,
        REG_DIST_PER_CNT = 3'd2,
        REG_GYRO_BIAS    = 3'd3,
        REG_SPEED_GAIN   = 3'd4,
        REG_HDG_GAIN     = 3'd5,
        REG_PWM_PERIOD   = 3'd6
    } cfg_reg_t;

endpackage

`default_nettype wire

// ----- rtl/diff_drive_speed_heading_control_core.sv -----
// an input transfer steps through states S_MDR to S_FIN and then S_OUT before m_tvalid rises
// one item at a time: s_tready is high only in S_IDLE, since the single shared 33x33 multiplier
// is stepped by the sequencer through ten products
// a result waiting in the output register stalls only the final step
// reset (aresetn low, synchronous): registers to defaults, filters, heading, duties zero
`default_nettype none

module diff_drive_speed_heading_control_core #(
    parameter int COUNT_BITS = ddsh_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = ddsh_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // right_position, left_position, gyro_rate, target_speed, target_heading, motor_enable
    input  wire logic [((2*COUNT_BITS+81+7)/8)*8-1:0] s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // right_forward_duty, right_reverse_duty, left_forward_duty, left_reverse_duty,
    // mean_speed, heading, angular_rate
    output logic [ddsh_pkg::M_DATA_W-1:0]          m_tdata,
    input  wire logic                              cfg_wr_en,
    input  wire logic [2:0]                        cfg_index,
    input  wire logic [ddsh_pkg::CFG_W-1:0]        cfg_wdata
);

    localparam int CB   = COUNT_BITS;
    localparam int PW   = ddsh_pkg::PROD_W;
    localparam int PS_W = PW - FRAC_BITS;
    localparam int OFS_G = 2 * CB;
    localparam int OFS_S = 2 * CB + 16;
    localparam int OFS_H = 2 * CB + 48;
    localparam int OFS_E = 2 * CB + 80;
    localparam logic signed [PS_W:0] U_ONE =
        {{(PS_W - FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_MDR, S_MDL, S_MFR, S_MFL, S_MFY, S_MEAN, S_MANG,
        S_HDG, S_MPS, S_MPH, S_SUM, S_MR, S_ML, S_FIN, S_OUT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
        if (v[PW-1:31] == '0 || v[PW-1:31] == '1) begin
            return v[31:0];
        end
        return v[PW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    endfunction

    function automatic logic signed [PW-1:0] wide(input logic signed [31:0] v);
        return $signed({{(PW-32){v[31]}}, v});
    endfunction

    function automatic logic signed [31:0] lowpass(input logic signed [31:0] old,
                                                   input logic signed [PW-1:0] prod);
        logic signed [PW-1:0] acc;
        acc = (wide(old) <<< 16) + prod + $signed(PW'(32768));
        return sat32(acc >>> 16);
    endfunction

    // configuration
    logic [16:0]        speed_coef_reg, yaw_coef_reg;
    logic [31:0]        dist_reg, speed_gain_reg, hdg_gain_reg;
    logic signed [15:0] gyro_bias_reg;
    logic [14:0]        period_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_coef_reg <= ddsh_pkg::SPEED_COEF_RST;
            yaw_coef_reg   <= ddsh_pkg::YAW_COEF_RST;
            dist_reg       <= ddsh_pkg::DIST_PER_CNT_RST;
            gyro_bias_reg  <= ddsh_pkg::GYRO_BIAS_RST;
            speed_gain_reg <= ddsh_pkg::SPEED_GAIN_RST;
            hdg_gain_reg   <= ddsh_pkg::HDG_GAIN_RST;
            period_reg     <= ddsh_pkg::PWM_PERIOD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ddsh_pkg::REG_SPEED_COEF:   speed_coef_reg <= cfg_wdata[16:0];
                ddsh_pkg::REG_YAW_COEF:     yaw_coef_reg   <= cfg_wdata[16:0];
                ddsh_pkg::REG_DIST_PER_CNT: dist_reg       <= cfg_wdata;
                ddsh_pkg::REG_GYRO_BIAS:    gyro_bias_reg  <= cfg_wdata[15:0];
                ddsh_pkg::REG_SPEED_GAIN:   speed_gain_reg <= cfg_wdata;
                ddsh_pkg::REG_HDG_GAIN:     hdg_gain_reg   <= cfg_wdata;
                ddsh_pkg::REG_PWM_PERIOD:   period_reg     <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    state_t                 state_reg;
    logic                   m_tvalid_reg;
    logic [ddsh_pkg::M_DATA_W-1:0] m_tdata_reg;

    logic [CB-1:0]          last_r_reg, last_l_reg;
    logic signed [CB-1:0]   dr_reg, dl_reg;
    logic signed [31:0]     ys_reg, tspd_reg, thdg_reg;
    logic                   en_reg;
    logic signed [31:0]     rs_reg, ls_reg, fy_reg, hs_reg, mean_reg, ang_reg;
    logic signed [31:0]     es_reg, eh_reg;
    logic signed [32:0]     diff_r_reg, diff_l_reg, diff_y_reg;
    logic [18:0]            q0_reg;
    logic [19:0]            rem_reg;
    logic                   neg_reg;
    logic signed [PS_W-1:0] ps_reg;
    logic [FRAC_BITS:0]     mag_r_reg, mag_l_reg;
    logic                   pos_r_reg, pos_l_reg;
    logic [14:0]            rf_reg, rr_reg, lf_reg, lr_reg;
    logic signed [PW-1:0]   p_reg;

    // input fields
    logic [CB-1:0]          in_rpos, in_lpos;
    logic signed [15:0]     in_gyro;
    logic signed [16:0]     gyro_diff;
    logic signed [PW-1:0]   gyro_wide;

    assign in_rpos   = s_tdata[CB-1:0];
    assign in_lpos   = s_tdata[2*CB-1:CB];
    assign in_gyro   = s_tdata[OFS_G+15:OFS_G];
    assign gyro_diff = $signed({in_gyro[15], in_gyro}) - $signed({gyro_bias_reg[15], gyro_bias_reg});
    assign gyro_wide = $signed({{(PW-17){gyro_diff[16]}}, gyro_diff}) <<< FRAC_BITS;

    // shared multiplier
    logic signed [32:0]   mul_a, mul_b;
    logic signed [PW-1:0] p_next;
    logic [16:0]          coef_s, coef_y;

    assign coef_s = (speed_coef_reg > ddsh_pkg::COEF_ONE) ? ddsh_pkg::COEF_ONE : speed_coef_reg;
    assign coef_y = (yaw_coef_reg > ddsh_pkg::COEF_ONE) ? ddsh_pkg::COEF_ONE : yaw_coef_reg;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MDR: begin
                mul_a = $signed({{(33-CB){dr_reg[CB-1]}}, dr_reg});
                mul_b = $signed({1'b0, dist_reg});
            end
            S_MDL: begin
                mul_a = $signed({{(33-CB){dl_reg[CB-1]}}, dl_reg});
                mul_b = $signed({1'b0, dist_reg});
            end
            S_MFR: begin
                mul_a = diff_r_reg;
                mul_b = $signed({16'd0, coef_s});
            end
            S_MFL: begin
                mul_a = diff_l_reg;
                mul_b = $signed({16'd0, coef_s});
            end
            S_MFY: begin
                mul_a = diff_y_reg;
                mul_b = $signed({16'd0, coef_y});
            end
            S_MANG: begin
                mul_a = $signed({fy_reg[31], fy_reg});
                mul_b = $signed(ddsh_pkg::ANG_K);
            end
            S_HDG: begin
                mul_a = $signed({es_reg[31], es_reg});
                mul_b = $signed({1'b0, speed_gain_reg});
            end
            S_MPH: begin
                mul_a = $signed({eh_reg[31], eh_reg});
                mul_b = $signed({1'b0, hdg_gain_reg});
            end
            S_MR: begin
                mul_a = $signed({{(32-FRAC_BITS){1'b0}}, mag_r_reg});
                mul_b = $signed({18'd0, period_reg});
            end
            S_ML: begin
                mul_a = $signed({{(32-FRAC_BITS){1'b0}}, mag_l_reg});
                mul_b = $signed({18'd0, period_reg});
            end
            default: ;
        endcase
    end

    assign p_next = mul_a * mul_b;

    // heading step: round(2*fy/32767) by folding the 2^15 remainder
    logic signed [33:0] y2;
    logic [33:0]        y2_abs, x_div;
    logic [18:0]        q0_next;
    logic [19:0]        rem_next;
    logic [4:0]         q1;
    logic [15:0]        rem1;
    logic [19:0]        quo;

    always_comb begin
        y2       = $signed({fy_reg[31], fy_reg, 1'b0});
        y2_abs   = y2[33] ? 34'(-y2) : 34'(y2);
        x_div    = y2_abs + {18'd0, ddsh_pkg::HALF_DIVISOR};
        q0_next  = x_div[33:15];
        rem_next = {5'd0, x_div[14:0]} + {1'b0, q0_next};
        q1       = rem_reg[19:15];
        rem1     = {1'b0, rem_reg[14:0]} + {11'd0, q1};
        quo      = {1'b0, q0_reg} + {15'd0, q1} + {19'd0, (rem1 >= ddsh_pkg::DIVISOR)};
    end

    // command sums and clamp
    logic signed [PS_W-1:0] ph;
    logic signed [PS_W:0]   u_r, u_l;
    logic signed [PS_W:0]   mean_sum;
    logic signed [32:0]     spd_sum;

    assign ph       = PS_W'(p_reg >>> FRAC_BITS);
    assign u_r      = $signed({ps_reg[PS_W-1], ps_reg}) + $signed({ph[PS_W-1], ph});
    assign u_l      = $signed({ps_reg[PS_W-1], ps_reg}) - $signed({ph[PS_W-1], ph});
    assign spd_sum  = $signed({rs_reg[31], rs_reg}) + $signed({ls_reg[31], ls_reg});
    assign mean_sum = '0;

    function automatic logic [FRAC_BITS:0] clamp_mag(input logic signed [PS_W:0] u);
        logic signed [PS_W:0] a;
        a = u[PS_W] ? -u : u;
        if (u > U_ONE || u < -U_ONE) begin
            return U_ONE[FRAC_BITS:0];
        end
        return a[FRAC_BITS:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            last_r_reg   <= '0;
            last_l_reg   <= '0;
            rs_reg       <= '0;
            ls_reg       <= '0;
            fy_reg       <= '0;
            hs_reg       <= '0;
            rf_reg       <= '0;
            rr_reg       <= '0;
            lf_reg       <= '0;
            lr_reg       <= '0;
        end else begin
            p_reg <= p_next;
            if (m_tvalid_reg && m_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        dr_reg     <= in_rpos - last_r_reg;
                        dl_reg     <= last_l_reg - in_lpos;
                        last_r_reg <= in_rpos;
                        last_l_reg <= in_lpos;
                        ys_reg     <= sat32(gyro_wide);
                        tspd_reg   <= s_tdata[OFS_S+31:OFS_S];
                        thdg_reg   <= s_tdata[OFS_H+31:OFS_H];
                        en_reg     <= s_tdata[OFS_E];
                        state_reg  <= S_MDR;
                    end
                end
                S_MDR: begin
                    diff_y_reg <= $signed({ys_reg[31], ys_reg}) - $signed({fy_reg[31], fy_reg});
                    state_reg  <= S_MDL;
                end
                S_MDL: begin
                    diff_r_reg <= 33'(wide(sat32(p_reg))) - $signed({rs_reg[31], rs_reg});
                    state_reg  <= S_MFR;
                end
                S_MFR: begin
                    diff_l_reg <= 33'(wide(sat32(p_reg))) - $signed({ls_reg[31], ls_reg});
                    state_reg  <= S_MFL;
                end
                S_MFL: begin
                    rs_reg    <= lowpass(rs_reg, p_reg);
                    state_reg <= S_MFY;
                end
                S_MFY: begin
                    ls_reg    <= lowpass(ls_reg, p_reg);
                    state_reg <= S_MEAN;
                end
                S_MEAN: begin
                    fy_reg    <= lowpass(fy_reg, p_reg);
                    mean_reg  <= spd_sum[32:1];
                    state_reg <= S_MANG;
                end
                S_MANG: begin
                    q0_reg    <= q0_next;
                    rem_reg   <= rem_next;
                    neg_reg   <= fy_reg[31];
                    es_reg    <= sat32(wide(tspd_reg) - wide(mean_reg));
                    state_reg <= S_HDG;
                end
                S_HDG: begin
                    ang_reg   <= 32'((p_reg + $signed(PW'(64'h8000_0000))) >>> 32);
                    hs_reg    <= neg_reg ? hs_reg - {12'd0, quo} : hs_reg + {12'd0, quo};
                    state_reg <= S_MPS;
                end
                S_MPS: begin
                    ps_reg    <= PS_W'(p_reg >>> FRAC_BITS);
                    eh_reg    <= sat32(wide(thdg_reg) - wide(hs_reg));
                    state_reg <= S_MPH;
                end
                S_MPH: begin
                    state_reg <= S_SUM;
                end
                S_SUM: begin
                    mag_r_reg <= clamp_mag(u_r);
                    mag_l_reg <= clamp_mag(u_l);
                    pos_r_reg <= (u_r > mean_sum);
                    pos_l_reg <= (u_l > mean_sum);
                    state_reg <= S_MR;
                end
                S_MR: begin
                    state_reg <= S_ML;
                end
                S_ML: begin
                    if (en_reg) begin
                        rf_reg <= pos_r_reg ? p_reg[FRAC_BITS+14:FRAC_BITS] : 15'd0;
                        rr_reg <= pos_r_reg ? 15'd0 : p_reg[FRAC_BITS+14:FRAC_BITS];
                    end
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (en_reg) begin
                        lf_reg <= pos_l_reg ? p_reg[FRAC_BITS+14:FRAC_BITS] : 15'd0;
                        lr_reg <= pos_l_reg ? 15'd0 : p_reg[FRAC_BITS+14:FRAC_BITS];
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    // output register free or being drained this cycle
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {4'd0, ang_reg, hs_reg, mean_reg,
                                         lr_reg, lf_reg, rr_reg, rf_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in work");

    a_bridge_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        (rf_reg == 15'd0 || rr_reg == 15'd0) && (lf_reg == 15'd0 || lr_reg == 15'd0))
        else $error("bridge driven forward and reverse at once");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && (!m_tvalid_reg || m_tready)) |=> (m_tvalid && s_tready))
        else $error("finished item did not reach the output register");

endmodule

`default_nettype wire

// ----- tb/sv/drive_cmd_checker.sv -----
`default_nettype none

module drive_cmd_checker
    import ddsh_pkg::*;
#(
    parameter int S_W = 112,
    parameter int M_W = M_DATA_W
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    input  wire logic           s_tready,
    input  wire logic [S_W-1:0] s_tdata,
    input  wire logic           m_tvalid,
    input  wire logic           m_tready,
    input  wire logic [M_W-1:0] m_tdata,
    input  wire logic           cfg_wr_en,
    input  wire logic [2:0]     cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    output int                  fail_count,
    output int                  pending,
    output int                  checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = COUNT_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam longint WEIGHT_ONE = 64'sd65536;
    localparam longint RAD_SCALE = 64'sd4575416;
    localparam longint GYRO_FULL = 64'sd32767;
    localparam longint GYRO_HALF = 64'sd16383;

    typedef struct packed {
        logic [14:0] rf;
        logic [14:0] rr;
        logic [14:0] lf;
        logic [14:0] lr;
        logic [31:0] mean;
        logic [31:0] hdg;
        logic [31:0] rate;
    } drive_cmd_t;

    // register copies
    longint spd_coef, yaw_coef, dist_per_cnt, gyro_bias, spd_gain, hdg_gain, period;

    // controller state
    logic [CB-1:0] prev_rpos, prev_lpos;
    longint rspd, lspd, yaw_filt;
    logic [31:0] heading_acc;
    logic [14:0] duty_hold [4];

    drive_cmd_t expected_cmds [$];
    drive_cmd_t want;
    int mismatches = 0;
    int results_checked = 0;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 100) begin
            $display("%0t ns mismatch: %s", $time, msg);
        end
    endtask

    function automatic longint clamp32(input longint v);
        if (v > S32_MAX) begin
            return S32_MAX;
        end
        if (v < S32_MIN) begin
            return S32_MIN;
        end
        return v;
    endfunction

    function automatic longint count_delta(input logic [CB-1:0] now, input logic [CB-1:0] prev);
        logic [CB-1:0] d;
        d = now - prev;
        return longint'($signed(d));
    endfunction

    function automatic longint smooth(input longint sample, input longint prev, input longint coef);
        longint c;
        c = (coef > WEIGHT_ONE) ? WEIGHT_ONE : coef;
        return clamp32((sample * c + prev * (WEIGHT_ONE - c) + 64'sd32768) >>> 16);
    endfunction

    function automatic void steer(input longint u, output logic [14:0] fwd,
                                  output logic [14:0] rev);
        longint one, mag;
        one = 64'sd1 <<< FB;
        if (u > one) begin
            u = one;
        end
        if (u < -one) begin
            u = -one;
        end
        mag = ((u < 0 ? -u : u) * period) >>> FB;
        if (mag > period) begin
            mag = period;
        end
        if (u > 0) begin
            fwd = mag[14:0];
            rev = '0;
        end else begin
            fwd = '0;
            rev = mag[14:0];
        end
    endfunction

    function automatic drive_cmd_t next_drive_cmd(input logic [S_W-1:0] d);
        logic [CB-1:0] rpos, lpos;
        longint gyro, ts, th, dr, dl, ys, y2, mag, q, mean, es, eh, ps, ph, ang;
        logic en;
        drive_cmd_t r;
        rpos = d[CB-1:0];
        lpos = d[2*CB-1:CB];
        gyro = longint'($signed(d[2*CB+15:2*CB]));
        ts = longint'($signed(d[2*CB+47:2*CB+16]));
        th = longint'($signed(d[2*CB+79:2*CB+48]));
        en = d[2*CB+80];

        // left wheel counts backward
        dr = count_delta(rpos, prev_rpos);
        dl = count_delta(prev_lpos, lpos);
        rspd = smooth(clamp32(dr * dist_per_cnt), rspd, spd_coef);
        lspd = smooth(clamp32(dl * dist_per_cnt), lspd, spd_coef);
        mean = (rspd + lspd) >>> 1;
        prev_rpos = rpos;
        prev_lpos = lpos;

        ys = clamp32((gyro - gyro_bias) * (64'sd1 <<< FB));
        yaw_filt = smooth(ys, yaw_filt, yaw_coef);
        y2 = 2 * yaw_filt;
        mag = ((y2 < 0 ? -y2 : y2) + GYRO_HALF) / GYRO_FULL;
        q = (y2 < 0) ? -mag : mag;
        heading_acc = heading_acc + q[31:0];
        ang = (yaw_filt * RAD_SCALE + (64'sd1 <<< 31)) >>> 32;

        if (en) begin
            es = clamp32(ts - mean);
            eh = clamp32(th - longint'($signed(heading_acc)));
            ps = (es * spd_gain) >>> FB;
            ph = (eh * hdg_gain) >>> FB;
            steer(ps + ph, duty_hold[0], duty_hold[1]);
            steer(ps - ph, duty_hold[2], duty_hold[3]);
        end

        r.rf = duty_hold[0];
        r.rr = duty_hold[1];
        r.lf = duty_hold[2];
        r.lr = duty_hold[3];
        r.mean = mean[31:0];
        r.hdg = heading_acc;
        r.rate = ang[31:0];
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            report_mismatch($sformatf("%s expected %h got %h", name, exp_v, got_v));
        end
    endtask

    task automatic check_cmd(input drive_cmd_t exp_c, input logic [M_W-1:0] d);
        compare_field("right_forward_duty", 32'(exp_c.rf), 32'(d[14:0]));
        compare_field("right_reverse_duty", 32'(exp_c.rr), 32'(d[29:15]));
        compare_field("left_forward_duty", 32'(exp_c.lf), 32'(d[44:30]));
        compare_field("left_reverse_duty", 32'(exp_c.lr), 32'(d[59:45]));
        compare_field("mean_speed", exp_c.mean, d[91:60]);
        compare_field("heading", exp_c.hdg, d[123:92]);
        compare_field("angular_rate", exp_c.rate, d[155:124]);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            spd_coef = 6554;
            yaw_coef = 6554;
            dist_per_cnt = 65536;
            gyro_bias = 0;
            spd_gain = 393216;
            hdg_gain = 983;
            period = 1000;
            prev_rpos = '0;
            prev_lpos = '0;
            rspd = 0;
            lspd = 0;
            yaw_filt = 0;
            heading_acc = '0;
            for (int i = 0; i < 4; i++) begin
                duty_hold[i] = '0;
            end
            expected_cmds.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SPEED_COEF:   spd_coef = cfg_wdata[16:0];
                    REG_YAW_COEF:     yaw_coef = cfg_wdata[16:0];
                    REG_DIST_PER_CNT: dist_per_cnt = cfg_wdata[31:0];
                    REG_GYRO_BIAS:    gyro_bias = longint'($signed(cfg_wdata[15:0]));
                    REG_SPEED_GAIN:   spd_gain = cfg_wdata[31:0];
                    REG_HDG_GAIN:     hdg_gain = cfg_wdata[31:0];
                    REG_PWM_PERIOD:   period = cfg_wdata[14:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                expected_cmds.push_back(next_drive_cmd(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                if (expected_cmds.size() == 0) begin
                    report_mismatch("result transfer with nothing expected");
                end else begin
                    want = expected_cmds.pop_front();
                    check_cmd(want, m_tdata);
                    results_checked++;
                end
            end
        end
        pending <= expected_cmds.size();
        fail_count <= mismatches;
        checked <= results_checked;
    end

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`default_nettype none

module tb_top;
    import ddsh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = COUNT_BITS_DEF;
    localparam int S_W = ((2 * CB + 81 + 7) / 8) * 8;
    localparam int M_W = M_DATA_W;
    localparam int SETTLE_CYCLES = 20;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 400;
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;
    localparam logic [15:0] G_MAX = 16'h7FFF;
    localparam logic [15:0] G_MIN = 16'h8000;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [S_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [M_W-1:0] m_tdata;
    logic cfg_wr_en;
    logic [2:0] cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    int fail_count;
    int pending;
    int checked;

    int send_idle_pct = 29;
    int stall_pct = 29;
    bit hold_off_req = 1'b0;
    bit hold_off_done = 1'b0;
    int items_sent = 0;
    int settings_loaded = 0;
    logic [CB-1:0] rpos_now = '0;
    logic [CB-1:0] lpos_now = '0;

    always #10 aclk = ~aclk;

    diff_drive_speed_heading_control_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    drive_cmd_checker #(.S_W(S_W), .M_W(M_W)) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    function automatic logic [S_W-1:0] pack_tick(input logic [CB-1:0] r, input logic [CB-1:0] l,
                                                 input logic [15:0] g, input logic [31:0] ts,
                                                 input logic [31:0] th, input logic en);
        return {{(S_W - 2 * CB - 81){1'b0}}, en, th, ts, g, l, r};
    endfunction

    // log-uniform magnitude, sign kept
    function automatic logic [31:0] spread32();
        int v;
        v = $urandom();
        return v >>> $urandom_range(0, 31);
    endfunction

    task automatic put_tick(input logic [S_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        items_sent++;
    endtask

    task automatic send_tick(input logic [CB-1:0] r, input logic [CB-1:0] l,
                             input logic [15:0] g, input logic [31:0] ts,
                             input logic [31:0] th, input logic en);
        rpos_now = r;
        lpos_now = l;
        put_tick(pack_tick(r, l, g, ts, th, en));
    endtask

    task automatic send_random_tick();
        int m;
        int g;
        logic [15:0] gyro;
        if ($urandom_range(99) < 85) begin
            // wheel motion: small or large steps, wrapping freely
            m = 1 << $urandom_range(0, CB - 1);
            rpos_now = rpos_now + CB'(int'($urandom_range(0, 2 * m)) - m);
            m = 1 << $urandom_range(0, CB - 1);
            lpos_now = lpos_now + CB'(int'($urandom_range(0, 2 * m)) - m);
        end else begin
            rpos_now = CB'($urandom());
            lpos_now = CB'($urandom());
        end
        g = $urandom();
        gyro = 16'(g >>> $urandom_range(16, 31));
        put_tick(pack_tick(rpos_now, lpos_now, gyro, spread32(), spread32(),
                           $urandom_range(99) < 85));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic load_settings(input logic [31:0] sc, input logic [31:0] yc,
                                 input logic [31:0] dpc, input logic [31:0] bias,
                                 input logic [31:0] sg, input logic [31:0] hg,
                                 input logic [31:0] per);
        wait_idle();
        write_reg(REG_SPEED_COEF, sc);
        write_reg(REG_YAW_COEF, yc);
        write_reg(REG_DIST_PER_CNT, dpc);
        write_reg(REG_GYRO_BIAS, bias);
        write_reg(REG_SPEED_GAIN, sg);
        write_reg(REG_HDG_GAIN, hg);
        write_reg(REG_PWM_PERIOD, per);
        // out-of-range index must be dropped
        write_reg(REG_UNUSED, $urandom());
        cfg_wr_en <= 1'b0;
        settings_loaded++;
    endtask

    function automatic logic [31:0] random_coef();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'd65536;
            2: return $urandom();
            default: return $urandom_range(1, 65536);
        endcase
    endfunction

    task automatic run_phase(input int idle, input int stall, input bit hold, input int n);
        logic [31:0] bias;
        logic [31:0] per;
        bias = ($urandom_range(3) == 0) ? $urandom() : 32'(int'($urandom_range(0, 400)) - 200);
        per = ($urandom_range(19) == 0) ? $urandom() : $urandom_range(1, 32767);
        load_settings(random_coef(), random_coef(), spread32(), bias, $urandom() >>
                      $urandom_range(0, 31), $urandom() >> $urandom_range(0, 31), per);
        send_idle_pct = idle;
        stall_pct = stall;
        if (hold) begin
            hold_off_req = 1'b1;
        end
        repeat (n) send_random_tick();
    endtask

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req && !hold_off_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_done = 1'b1;
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_SPEED_COEF;
        cfg_wdata <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register defaults, encoder wrap both ways, duty hold
        send_tick(0, 0, 16'd0, 32'd0, 32'd0, 1'b1);
        send_tick(16383, 16383, G_MAX, Q_MAX, Q_MAX, 1'b1);
        send_tick(0, 0, G_MIN, Q_MIN, Q_MIN, 1'b1);
        send_tick(8192, 8191, 16'd100, 32'd65536, 32'd0, 1'b0);
        send_tick(16383, 0, -16'sd100, -32'sd65536, 32'd0, 1'b0);
        send_tick(16383, 0, 16'd0, 32'd0, 32'd0, 1'b1);

        // full weights, max gains and period, most negative bias
        load_settings(32'd65536, 32'd65536, 32'd1, 32'hFFFF_8000, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'd32767);
        send_tick(100, 16283, G_MAX, Q_MAX, Q_MIN, 1'b1);
        send_tick(0, 0, G_MIN, Q_MIN, Q_MAX, 1'b1);
        send_tick(5000, 11383, 16'd0, 32'd0, 32'd0, 1'b1);

        // zero weights and gains, smallest period
        load_settings(32'd0, 32'd0, 32'd0, 32'd32767, 32'd0, 32'd0, 32'd1);
        send_tick(8000, 8000, G_MAX, Q_MAX, Q_MAX, 1'b1);
        send_tick(0, 0, G_MIN, 32'd1, 32'hFFFF_FFFF, 1'b1);

        // weights above one, huge scale, period masked to zero
        load_settings(32'hFFFF_FFFF, 32'd65537, 32'hFFFF_FFFF, 32'hABCD_0000, 32'd65536,
                      32'd65536, 32'd32768);
        send_tick(8191, 8193, G_MAX, Q_MAX, Q_MAX, 1'b1);
        send_tick(0, 0, G_MIN, Q_MIN, Q_MIN, 1'b1);
        send_tick(1, 16383, 16'd1, 32'd0, 32'd0, 1'b0);

        run_phase(0, 0, 1'b1, PHASE_ITEMS);
        run_phase(73, 0, 1'b0, PHASE_ITEMS);
        run_phase(0, 73, 1'b0, PHASE_ITEMS);
        run_phase(29, 29, 1'b0, PHASE_ITEMS);
        run_phase(0, 0, 1'b0, PHASE_ITEMS);

        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d control ticks under %0d register loads, %0d results compared",
                 items_sent, settings_loaded, checked);
        $display("including duty hold, encoder wrap, saturation, zero period, output back-pressure");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout waiting for the block");
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
